FILE: hw/rtl/bldc6_pkg.sv
// Shared types, codes and six-step tables for the BLDC six-step commutator.
package bldc6_pkg;

    // Event kinds
    localparam logic [2:0] KIND_ZC    = 3'd0;
    localparam logic [2:0] KIND_MISS  = 3'd1;
    localparam logic [2:0] KIND_FORCE = 3'd2;
    localparam logic [2:0] KIND_DUTY  = 3'd3;
    localparam logic [2:0] KIND_BRAKE = 3'd4;

    // Motor modes
    localparam logic [2:0] MODE_DISARMED = 3'd0;
    localparam logic [2:0] MODE_NO_COMM  = 3'd1;
    localparam logic [2:0] MODE_STARTING = 3'd2;
    localparam logic [2:0] MODE_RUNNING  = 3'd3;

    // Alarm commands
    localparam logic [1:0] ALARM_NONE       = 2'd0;
    localparam logic [1:0] ALARM_CANCEL     = 2'd1;
    localparam logic [1:0] ALARM_SET        = 2'd2;
    localparam logic [1:0] ALARM_CANCEL_SET = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_REVERSE   = 2'd0;
    localparam logic [1:0] REG_BRAKE_EN  = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;
    localparam logic [1:0] REG_MAX_DELAY = 2'd3;

    localparam logic [2:0]  STEP_OFF  = 3'd0;
    localparam logic [2:0]  STEP_LAST = 3'd6;
    localparam logic [2:0]  STEP_FIRST = 3'd1;
    localparam logic [15:0] DELAY_MAX = 16'hffff;

    // Decoded view of one step
    typedef struct packed {
        logic [2:0] applied;   // step 0..6
        logic [2:0] following; // next expected step
        logic [2:0] high_en;   // high side PWM enables, bit0 A
        logic [2:0] low_on;    // low side gates, bit0 A
    } t_step_info;

    // High side enables per step
    function automatic logic [2:0] high_pattern(input logic [2:0] s);
        logic [2:0] p;
        case (s)
            3'd1:    p = 3'b001;
            3'd2:    p = 3'b100;
            3'd3:    p = 3'b100;
            3'd4:    p = 3'b010;
            3'd5:    p = 3'b010;
            3'd6:    p = 3'b001;
            default: p = 3'b000;
        endcase
        return p;
    endfunction

    // Low side gates per step; off state keeps phase B low
    function automatic logic [2:0] low_pattern(input logic [2:0] s);
        logic [2:0] p;
        case (s)
            3'd3:    p = 3'b001;
            3'd4:    p = 3'b001;
            3'd5:    p = 3'b100;
            3'd6:    p = 3'b100;
            default: p = 3'b010;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/bldc6_step_unit.sv
// Step decode: clamps the requested step, looks up gate patterns, finds the next step.
module bldc6_step_unit (
    input  logic [2:0]            i_step,
    input  logic                  i_reverse,
    output bldc6_pkg::t_step_info o_info
);
    import bldc6_pkg::*;

    logic [2:0] w_step;
    logic [2:0] w_next;

    // Step seven maps to off
    assign w_step = (i_step > STEP_LAST) ? STEP_OFF : i_step;

    // Wrap in the selected direction; off always leads to step 1
    always_comb begin
        if (i_reverse) begin
            if (w_step == STEP_OFF) begin
                w_next = STEP_FIRST;
            end else if (w_step == STEP_FIRST) begin
                w_next = STEP_LAST;
            end else begin
                w_next = w_step - 3'd1;
            end
        end else begin
            w_next = (w_step >= STEP_LAST) ? STEP_FIRST : w_step + 3'd1;
        end
    end

    assign o_info.applied   = w_step;
    assign o_info.following = w_next;
    assign o_info.high_en   = high_pattern(w_step);
    assign o_info.low_on    = low_pattern(w_step);

endmodule

FILE: hw/rtl/bldc_six_step_commutator.sv
// Top level of the sensorless BLDC six-step commutator.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser kind, tdata event fields
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata gate pattern, steps, alarm, counts
//  cfg       in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One event gives one result. An event is held in the input register,
// is evaluated against the state and lands in the result register; one event
// per cycle is sustained while m_axis_tready is high.
// The result register stalls under backpressure and the input register fills
// behind it. Reset (synchronous, active low) loads the register defaults and
// the state values; no clearing pass is needed.
module bldc_six_step_commutator #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Event input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] step_value, [18:3] zc_period, [21:19] motor_mode,
    // [37:22] duty_request, [38] brake_request, [39] zero
    input  logic [39:0]  s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]   s_axis_tuser,
    // Result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] high_pwm_enables, [5:3] low_gates_on, [6] low_pwm_mode,
    // [9:7] applied_step, [12:10] expected_step, [14:13] alarm_action,
    // [30:15] alarm_delay, [46:31] good_detects, [62:47] bad_detects,
    // [78:63] all_bad_detects, [94:79] high_compare, [110:95] low_compare,
    // [111] zero
    output logic [111:0] m_axis_tdata,
    // Configuration writes
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import bldc6_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNTER_WIDTH-1:0] GOOD_CLEAR = COUNTER_WIDTH'(6);

    // Configuration registers
    logic        r_reverse;
    logic        r_brake_en;
    logic [15:0] r_period;
    logic [15:0] r_max_delay;

    // Input register
    logic        r_in_vld;
    logic [2:0]  r_in_kind;
    logic [2:0]  r_in_step;
    logic [15:0] r_in_zc;
    logic [2:0]  r_in_mode;
    logic [15:0] r_in_duty;
    logic        r_in_brake;

    // Commutation state
    logic [2:0]               r_cur_step,  n_cur_step;
    logic [2:0]               r_fol_step,  n_fol_step;
    logic [COUNTER_WIDTH-1:0] r_good,      n_good;
    logic [COUNTER_WIDTH-1:0] r_bad,       n_bad;
    logic [COUNTER_WIDTH-1:0] r_total_bad, n_total_bad;
    logic [15:0]              r_alarm_arg, n_alarm_arg;
    logic                     r_brake_st,  n_brake_st;
    logic                     r_low_mode,  n_low_mode;
    logic [15:0]              r_hi_cmp,    n_hi_cmp;
    logic [15:0]              r_lo_cmp,    n_lo_cmp;

    // Result register
    logic         r_out_vld;
    logic [111:0] r_out_data;

    logic       w_adv;
    logic       w_apply;
    logic [2:0] w_apply_step;
    t_step_info w_info;
    t_step_info w_show;

    logic [1:0]  w_action;
    logic [15:0] w_delay;
    logic [16:0] w_zc_delay;
    logic [16:0] w_miss_delay;
    logic [15:0] w_duty;
    logic [16:0] w_lo_sum;
    logic        w_match;

    logic [COUNTER_WIDTH+15:0] w_good_ext;
    logic [COUNTER_WIDTH+15:0] w_bad_ext;
    logic [COUNTER_WIDTH+15:0] w_tbad_ext;

    // Pipeline flow: move the held event into the result register when it is free
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse   <= 1'b0;
            r_brake_en  <= 1'b0;
            r_period    <= 16'd1800;
            r_max_delay <= 16'hffff;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REVERSE:   r_reverse   <= i_cfg_data[0];
                REG_BRAKE_EN:  r_brake_en  <= i_cfg_data[0];
                REG_PERIOD:    r_period    <= i_cfg_data;
                REG_MAX_DELAY: r_max_delay <= i_cfg_data;
                default:       r_reverse   <= r_reverse;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind  <= s_axis_tuser;
            r_in_step  <= s_axis_tdata[2:0];
            r_in_zc    <= s_axis_tdata[18:3];
            r_in_mode  <= s_axis_tdata[21:19];
            r_in_duty  <= s_axis_tdata[37:22];
            r_in_brake <= s_axis_tdata[38];
        end
    end

    // Step being applied by this event
    bldc6_step_unit u_step (
        .i_step    (w_apply_step),
        .i_reverse (r_reverse),
        .o_info    (w_info)
    );

    assign w_match      = (r_in_step == r_fol_step);
    assign w_zc_delay   = {1'b0, r_in_zc} + {2'b00, r_in_zc[15:1]};
    assign w_miss_delay = {1'b0, r_alarm_arg} + {3'b000, r_alarm_arg[15:2]};
    assign w_duty       = (r_in_duty > r_period) ? r_period : r_in_duty;
    assign w_lo_sum     = {1'b0, w_duty} + {4'b0000, r_period[15:3]};

    // Event evaluation
    always_comb begin
        n_cur_step   = r_cur_step;
        n_fol_step   = r_fol_step;
        n_good       = r_good;
        n_bad        = r_bad;
        n_total_bad  = r_total_bad;
        n_alarm_arg  = r_alarm_arg;
        n_brake_st   = r_brake_st;
        n_low_mode   = r_low_mode;
        n_hi_cmp     = r_hi_cmp;
        n_lo_cmp     = r_lo_cmp;
        w_action     = ALARM_NONE;
        w_delay      = 16'd0;
        w_apply      = 1'b0;
        w_apply_step = r_in_step;

        case (r_in_kind)
            KIND_ZC: begin
                if (r_in_mode != MODE_NO_COMM) begin
                    if (w_match) begin
                        w_apply  = 1'b1;
                        w_action = ALARM_CANCEL;
                        n_good   = (r_good == CNT_MAX) ? r_good : r_good + 1'b1;
                        if (n_good >= GOOD_CLEAR) begin
                            n_bad = '0;
                        end
                        if (r_in_mode == MODE_STARTING || r_in_mode == MODE_RUNNING) begin
                            w_delay     = w_zc_delay[16] ? DELAY_MAX : w_zc_delay[15:0];
                            n_alarm_arg = r_in_zc;
                            w_action    = ALARM_CANCEL_SET;
                        end
                    end else begin
                        n_bad       = (r_bad == CNT_MAX) ? r_bad : r_bad + 1'b1;
                        n_total_bad = (r_total_bad == CNT_MAX) ? r_total_bad
                                                               : r_total_bad + 1'b1;
                        n_good      = '0;
                    end
                end
            end
            KIND_MISS: begin
                w_apply      = 1'b1;
                w_apply_step = r_fol_step;
                w_action     = ALARM_SET;
                w_delay      = (w_miss_delay > {1'b0, r_max_delay}) ? r_max_delay
                                                                    : w_miss_delay[15:0];
            end
            KIND_FORCE: begin
                w_apply = 1'b1;
            end
            KIND_DUTY: begin
                n_hi_cmp = (r_in_mode == MODE_DISARMED) ? 16'd0 : w_duty;
                if (r_brake_en) begin
                    n_lo_cmp = (w_lo_sum > {1'b0, r_period}) ? r_period : w_lo_sum[15:0];
                end
            end
            KIND_BRAKE: begin
                n_brake_st = r_in_brake;
                n_low_mode = r_in_brake;
            end
            default: begin
                w_apply = 1'b0;
            end
        endcase

        // Commit a step change
        if (w_apply) begin
            n_cur_step = w_info.applied;
            n_fol_step = w_info.following;
            if (r_brake_en) begin
                n_low_mode = r_brake_st;
            end
        end
    end

    // Pattern for the step shown in the result
    assign w_show.applied   = n_cur_step;
    assign w_show.following = n_fol_step;
    assign w_show.high_en   = high_pattern(n_cur_step);
    assign w_show.low_on    = low_pattern(n_cur_step);

    // Counters reported in 16 bits
    assign w_good_ext = {16'd0, n_good};
    assign w_bad_ext  = {16'd0, n_bad};
    assign w_tbad_ext = {16'd0, n_total_bad};

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_step  <= STEP_OFF;
            r_fol_step  <= STEP_FIRST;
            r_good      <= '0;
            r_bad       <= '0;
            r_total_bad <= '0;
            r_alarm_arg <= 16'd0;
            r_brake_st  <= 1'b0;
            r_low_mode  <= 1'b0;
            r_hi_cmp    <= 16'd0;
            r_lo_cmp    <= 16'd0;
        end else if (w_adv) begin
            r_cur_step  <= n_cur_step;
            r_fol_step  <= n_fol_step;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_total_bad <= n_total_bad;
            r_alarm_arg <= n_alarm_arg;
            r_brake_st  <= n_brake_st;
            r_low_mode  <= n_low_mode;
            r_hi_cmp    <= n_hi_cmp;
            r_lo_cmp    <= n_lo_cmp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {1'b0,
                           n_lo_cmp,
                           n_hi_cmp,
                           w_tbad_ext[15:0],
                           w_bad_ext[15:0],
                           w_good_ext[15:0],
                           w_delay,
                           w_action,
                           w_show.following,
                           w_show.applied,
                           n_low_mode,
                           w_show.low_on,
                           w_show.high_en};
        end
    end

endmodule
